// ===== hdl/pfa_pkg.sv =====
// Package: shared codes, field widths and reset values of the partition allocator.
`default_nettype none
package pfa_pkg;
	localparam int REQ_W     = 20;
	localparam int IDX_W     = 6;
	localparam int STATUS_W  = 3;
	localparam int CFG_W     = 20;
	localparam int CFG_IDX_W = 2;

	typedef logic [STATUS_W-1:0] status_t;

	localparam status_t ST_OK     = 3'd0;
	localparam status_t ST_ZERO   = 3'd1;
	localparam status_t ST_NOFIT  = 3'd2;
	localparam status_t ST_FULL   = 3'd3;
	localparam status_t ST_BADIDX = 3'd4;

	localparam logic OP_ALLOC = 1'b0;
	localparam logic OP_FREE  = 1'b1;

	localparam logic [1:0] POL_FIRST = 2'd0;
	localparam logic [1:0] POL_BEST  = 2'd1;
	localparam logic [1:0] POL_WORST = 2'd2;
	// spare policy code, behaves as worst fit
	localparam logic [1:0] POL_SPARE = 2'd3;

	localparam logic [CFG_IDX_W-1:0] CFG_POLICY   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_RESERVED = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_POOL     = 2'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_BASE     = 2'd3;

	localparam logic [CFG_W-1:0] RESERVED_RST = 20'd40;
	localparam logic [CFG_W-1:0] POOL_RST     = 20'd600;
endpackage
`default_nettype wire

// ===== hdl/pfa_if.sv =====
// Interfaces: request and response channels of the partition allocator.
`default_nettype none
interface pfa_req_if;
	logic                          valid;
	logic                          ready;
	logic                          opcode;
	logic [pfa_pkg::REQ_W-1:0]     request_size;
	logic [pfa_pkg::IDX_W-1:0]     part_index;
	modport source (output valid, opcode, request_size, part_index, input ready);
	modport sink   (input valid, opcode, request_size, part_index, output ready);
endinterface

interface pfa_rsp_if;
	logic                          valid;
	logic                          ready;
	logic [pfa_pkg::STATUS_W-1:0]  status;
	logic [pfa_pkg::IDX_W-1:0]     result_index;
	modport source (output valid, status, result_index, input ready);
	modport sink   (input valid, status, result_index, output ready);
endinterface
`default_nettype wire

// ===== hdl/pfa_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port with registered data.
`default_nettype none
module pfa_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	// write and registered read
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule
`default_nettype wire

// ===== hdl/partition_allocator_fit_top.sv =====
// Partition allocator: table in one RAM, scan for a fitting hole, shift on split/merge.
// Flow, from the request transfer to a valid response: allocate scans the table for a
//   hole and, on a split, shifts the later entries up and writes both halves; free reads
//   the left, middle and right entries and, on a merge, moves the later entries down.
//   A zero size or an out-of-range index answers without touching the table.
// Throughput: one request at a time, bounded by the single RAM read and write port.
// Reset and any register write rebuild entries 0 and 1 in states S_REB0 and S_REB1; no request
//   is taken meanwhile.
`default_nettype none
module partition_allocator_fit_top #(
	parameter int MAX_PARTITIONS = 64,
	parameter int ADDR_BITS      = 20
) (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             cfg_we,
	input  wire logic [pfa_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  wire logic [pfa_pkg::CFG_W-1:0]        cfg_data,
	pfa_req_if.sink                               req,
	pfa_rsp_if.source                             rsp
);
	localparam int IW   = $clog2(MAX_PARTITIONS);
	localparam int CNTW = $clog2(MAX_PARTITIONS + 1);
	localparam int SW   = (ADDR_BITS > pfa_pkg::REQ_W) ? ADDR_BITS : pfa_pkg::REQ_W;
	localparam int XW   = (CNTW > pfa_pkg::IDX_W) ? CNTW : pfa_pkg::IDX_W;
	localparam logic [SW-1:0] AMASK = SW'((64'd1 << ADDR_BITS) - 64'd1);
	localparam logic [CNTW-1:0] MAXC = CNTW'(MAX_PARTITIONS);

	typedef struct packed {
		logic [ADDR_BITS-1:0] start;
		logic [SW-1:0]        size;
		logic                 used;
	} entry_t;

	typedef enum logic [3:0] {
		S_REB0, S_REB1, S_IDLE, S_SCAN, S_DEC, S_SHIFT, S_WRA, S_WRB,
		S_FR0, S_FR1, S_FR2, S_FDEC, S_DONE
	} state_t;

	state_t               state_q;
	logic [1:0]           policy_q;
	logic [pfa_pkg::CFG_W-1:0] reserved_q, pool_q, base_q;
	logic [CNTW-1:0]      count_q;
	logic [SW-1:0]        req_q;
	logic [CNTW-1:0]      idx_q;
	logic [CNTW-1:0]      scan_ptr_q;
	logic                 found_q;
	logic [CNTW-1:0]      cand_idx_q;
	entry_t               cand_q;
	entry_t               left_q, mid_q;
	logic [CNTW-1:0]      sh_ptr_q, sh_lim_q;
	logic                 sh_up_q, sh_two_q;
	logic                 rd_v_s1;
	logic [CNTW-1:0]      rd_idx_s1;
	pfa_pkg::status_t     res_status_q;
	logic [CNTW-1:0]      res_idx_q;
	logic                 out_v_q;
	pfa_pkg::status_t     out_status_q;
	logic [pfa_pkg::IDX_W-1:0] out_idx_q;

	logic                 ram_we;
	logic [IW-1:0]        ram_waddr, ram_raddr;
	entry_t               ram_wdata, ram_rdata;
	logic                 rd_issue;
	logic [CNTW-1:0]      rd_ptr;
	logic                 sh_more;
	logic                 in_xfer;
	logic                 eligible, take;
	logic                 free_bad;
	logic                 r_ok, l_free, r_free;
	logic [SW-1:0]        cfg_base_w, cfg_res_w;

	pfa_ram #(.WIDTH($bits(entry_t)), .DEPTH(MAX_PARTITIONS)) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	assign in_xfer   = req.valid && req.ready;
	assign req.ready = (state_q == S_IDLE);
	assign rsp.valid        = out_v_q;
	assign rsp.status       = out_status_q;
	assign rsp.result_index = out_idx_q;

	assign cfg_base_w = SW'(base_q);
	assign cfg_res_w  = SW'(reserved_q);

	// free index check against the current table
	assign free_bad = (XW'(req.part_index) == '0) ||
		(XW'(req.part_index) >= XW'(count_q));

	// hole selection on the entry coming back from the RAM
	assign eligible = !ram_rdata.used && (ram_rdata.size >= req_q);
	always_comb begin
		take = 1'b0;
		if (eligible) begin
			if (!found_q) begin
				take = 1'b1;
			end else if (policy_q == pfa_pkg::POL_FIRST) begin
				take = 1'b0;
			end else if (policy_q == pfa_pkg::POL_BEST) begin
				take = ram_rdata.size < cand_q.size;
			end else begin
				take = ram_rdata.size > cand_q.size;
			end
		end
	end

	// neighbor state for a free
	assign r_ok   = (idx_q + CNTW'(1)) < count_q;
	assign l_free = !left_q.used;
	assign r_free = r_ok && !ram_rdata.used;

	assign sh_more = sh_up_q ? (sh_ptr_q > sh_lim_q) : (sh_ptr_q < sh_lim_q);

	// read address and issue
	always_comb begin
		rd_issue = 1'b0;
		rd_ptr   = '0;
		case (state_q)
			S_SCAN: begin
				rd_issue = scan_ptr_q < count_q;
				rd_ptr   = scan_ptr_q;
			end
			S_SHIFT: begin
				rd_issue = sh_more;
				rd_ptr   = sh_ptr_q;
			end
			S_FR0:   rd_ptr = idx_q - CNTW'(1);
			S_FR1:   rd_ptr = idx_q;
			S_FR2:   rd_ptr = idx_q + CNTW'(1);
			default: rd_ptr = '0;
		endcase
		ram_raddr = rd_ptr[IW-1:0];
	end

	// write port
	always_comb begin
		logic [CNTW-1:0] waddr_c;
		ram_we    = 1'b0;
		waddr_c   = '0;
		ram_wdata = '0;
		case (state_q)
			S_REB0: begin
				ram_we    = 1'b1;
				waddr_c   = '0;
				ram_wdata = '{ADDR_BITS'(cfg_base_w), cfg_res_w & AMASK, 1'b1};
			end
			S_REB1: begin
				ram_we    = 1'b1;
				waddr_c   = CNTW'(1);
				ram_wdata = '{ADDR_BITS'(cfg_base_w + cfg_res_w), SW'(pool_q) & AMASK, 1'b0};
			end
			S_DEC: begin
				ram_we    = found_q && (cand_q.size == req_q);
				waddr_c   = cand_idx_q;
				ram_wdata = '{cand_q.start, cand_q.size, 1'b1};
			end
			S_SHIFT: begin
				ram_we    = rd_v_s1;
				waddr_c   = sh_up_q ? (rd_idx_s1 + CNTW'(1)) :
					(rd_idx_s1 - (sh_two_q ? CNTW'(2) : CNTW'(1)));
				ram_wdata = ram_rdata;
			end
			S_WRA: begin
				ram_we    = 1'b1;
				waddr_c   = cand_idx_q;
				ram_wdata = '{cand_q.start, req_q, 1'b1};
			end
			S_WRB: begin
				ram_we    = 1'b1;
				waddr_c   = cand_idx_q + CNTW'(1);
				ram_wdata = '{ADDR_BITS'(SW'(cand_q.start) + req_q),
					(cand_q.size - req_q) & AMASK, 1'b0};
			end
			S_FDEC: begin
				ram_we = mid_q.used;
				if (l_free) begin
					waddr_c   = idx_q - CNTW'(1);
					ram_wdata = '{left_q.start,
						(left_q.size + mid_q.size + (r_free ? ram_rdata.size : '0)) & AMASK,
						1'b0};
				end else begin
					waddr_c   = idx_q;
					ram_wdata = '{mid_q.start,
						(mid_q.size + (r_free ? ram_rdata.size : '0)) & AMASK, 1'b0};
				end
			end
			default: ram_we = 1'b0;
		endcase
		ram_waddr = waddr_c[IW-1:0];
	end

	// control, configuration and registered response
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_REB0;
			policy_q   <= pfa_pkg::POL_FIRST;
			reserved_q <= pfa_pkg::RESERVED_RST;
			pool_q     <= pfa_pkg::POOL_RST;
			base_q     <= '0;
			count_q    <= CNTW'(2);
			rd_v_s1    <= 1'b0;
			out_v_q    <= 1'b0;
			found_q    <= 1'b0;
		end else begin
			rd_v_s1   <= rd_issue;
			rd_idx_s1 <= rd_ptr;
			// response register: load from the done state, clear on a transfer
			if ((state_q == S_DONE) && !cfg_we && (!out_v_q || rsp.ready)) begin
				out_v_q <= 1'b1;
			end else if (rsp.ready) begin
				out_v_q <= 1'b0;
			end
			if (cfg_we) begin
				// register write rebuilds the table
				unique case (cfg_index)
					pfa_pkg::CFG_POLICY:   policy_q   <= cfg_data[1:0];
					pfa_pkg::CFG_RESERVED: reserved_q <= cfg_data;
					pfa_pkg::CFG_POOL:     pool_q     <= cfg_data;
					pfa_pkg::CFG_BASE:     base_q     <= cfg_data;
					default:               policy_q   <= policy_q;
				endcase
				state_q <= S_REB0;
			end else begin
				unique case (state_q)
					S_REB0: state_q <= S_REB1;
					S_REB1: begin
						count_q <= CNTW'(2);
						state_q <= S_IDLE;
					end
					S_IDLE: begin
						if (in_xfer) begin
							req_q   <= SW'(req.request_size);
							idx_q   <= CNTW'(req.part_index);
							res_idx_q <= '0;
							if (req.opcode == pfa_pkg::OP_ALLOC) begin
								if (req.request_size == '0) begin
									res_status_q <= pfa_pkg::ST_ZERO;
									state_q      <= S_DONE;
								end else begin
									scan_ptr_q <= '0;
									found_q    <= 1'b0;
									state_q    <= S_SCAN;
								end
							end else if (free_bad) begin
								res_status_q <= pfa_pkg::ST_BADIDX;
								state_q      <= S_DONE;
							end else begin
								state_q <= S_FR0;
							end
						end
					end
					S_SCAN: begin
						if (rd_issue) begin
							scan_ptr_q <= scan_ptr_q + CNTW'(1);
						end
						if (rd_v_s1 && take) begin
							found_q    <= 1'b1;
							cand_idx_q <= rd_idx_s1;
							cand_q     <= ram_rdata;
						end
						if (!rd_issue && !rd_v_s1) begin
							state_q <= S_DEC;
						end
					end
					S_DEC: begin
						if (!found_q) begin
							res_status_q <= pfa_pkg::ST_NOFIT;
							state_q      <= S_DONE;
						end else if (cand_q.size == req_q) begin
							res_status_q <= pfa_pkg::ST_OK;
							res_idx_q    <= cand_idx_q;
							state_q      <= S_DONE;
						end else if (count_q == MAXC) begin
							res_status_q <= pfa_pkg::ST_FULL;
							state_q      <= S_DONE;
						end else begin
							sh_up_q  <= 1'b1;
							sh_two_q <= 1'b0;
							sh_ptr_q <= count_q - CNTW'(1);
							sh_lim_q <= cand_idx_q;
							state_q  <= S_SHIFT;
						end
					end
					S_SHIFT: begin
						if (rd_issue) begin
							sh_ptr_q <= sh_up_q ? (sh_ptr_q - CNTW'(1)) :
								(sh_ptr_q + CNTW'(1));
						end
						if (!rd_issue && !rd_v_s1) begin
							state_q <= sh_up_q ? S_WRA : S_DONE;
						end
					end
					S_WRA: state_q <= S_WRB;
					S_WRB: begin
						count_q      <= count_q + CNTW'(1);
						res_status_q <= pfa_pkg::ST_OK;
						res_idx_q    <= cand_idx_q;
						state_q      <= S_DONE;
					end
					S_FR0: state_q <= S_FR1;
					S_FR1: begin
						left_q  <= ram_rdata;
						state_q <= S_FR2;
					end
					S_FR2: begin
						mid_q   <= ram_rdata;
						state_q <= S_FDEC;
					end
					S_FDEC: begin
						sh_up_q  <= 1'b0;
						sh_two_q <= l_free && r_free;
						sh_lim_q <= count_q;
						sh_ptr_q <= (l_free && !r_free) ? (idx_q + CNTW'(1)) :
							(idx_q + CNTW'(2));
						res_status_q <= mid_q.used ? pfa_pkg::ST_OK : pfa_pkg::ST_BADIDX;
						if (!mid_q.used || (!l_free && !r_free)) begin
							state_q <= S_DONE;
						end else begin
							count_q <= count_q - ((l_free && r_free) ? CNTW'(2) : CNTW'(1));
							state_q <= S_SHIFT;
						end
					end
					S_DONE: begin
						if (!out_v_q || rsp.ready) begin
							out_status_q <= res_status_q;
							out_idx_q    <= pfa_pkg::IDX_W'(res_idx_q);
							state_q      <= S_IDLE;
						end
					end
					default: state_q <= S_IDLE;
				endcase
			end
		end
	end

	// table size stays within its bounds
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q >= CNTW'(2)) && (count_q <= MAXC))
		else $error("entry count out of range");

	// no table writes while waiting for a request
	a_idle_no_write: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE) |-> !ram_we)
		else $error("RAM write while idle");

	// a zero-size allocate answers without touching the table
	a_zero_req: assert property (@(posedge clk) disable iff (!arst_n)
		(in_xfer && (req.opcode == pfa_pkg::OP_ALLOC) && (req.request_size == '0) && !cfg_we)
		|=> (state_q == S_DONE) && (res_status_q == pfa_pkg::ST_ZERO))
		else $error("zero-size allocate not rejected");

	// a split always grows the table by one
	a_split_grow: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_WRB) && !cfg_we |=> count_q == $past(count_q) + CNTW'(1))
		else $error("split did not grow the table");
endmodule
`default_nettype wire

// ===== dv/pfa_tb_if.sv =====
// Testbench package: response item type used by the allocator checker.
`default_nettype none
package pfa_tb_pkg;
	typedef struct packed {
		pfa_pkg::status_t                status;
		logic [pfa_pkg::IDX_W-1:0]       result_index;
	} alloc_rsp_t;
endpackage
`default_nettype wire

// ===== dv/pfa_checker.sv =====
// Checker: watches the request and response transfers, predicts the table and compares.
`default_nettype none
module pfa_checker (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          cfg_we,
	input  wire logic [pfa_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic [pfa_pkg::CFG_W-1:0]     cfg_data,
	input  wire logic                          req_valid,
	input  wire logic                          req_ready,
	input  wire logic                          req_opcode,
	input  wire logic [pfa_pkg::REQ_W-1:0]     req_size,
	input  wire logic [pfa_pkg::IDX_W-1:0]     req_index,
	input  wire logic                          rsp_valid,
	input  wire logic                          rsp_ready,
	input  wire logic [pfa_pkg::STATUS_W-1:0]  rsp_status,
	input  wire logic [pfa_pkg::IDX_W-1:0]     rsp_index,
	output int                                 errors,
	output int                                 pending
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam int NPART = 64;
	localparam int IDX_W = pfa_pkg::IDX_W;

	logic [1:0]  policy;
	logic [19:0] os_size, free_size, base_addr;
	logic [19:0] p_start [NPART];
	logic [19:0] p_size  [NPART];
	logic        p_used  [NPART];
	int          p_count;
	pfa_tb_pkg::alloc_rsp_t expected_rsp [$];

	function automatic void rebuild_table();
		for (int i = 0; i < NPART; i++) begin
			p_start[i] = '0;
			p_size[i] = '0;
			p_used[i] = 1'b0;
		end
		p_start[0] = base_addr;
		p_size[0] = os_size;
		p_used[0] = 1'b1;
		p_start[1] = base_addr + os_size;
		p_size[1] = free_size;
		p_count = 2;
	endfunction

	function automatic void drop_entry(int idx);
		for (int i = idx; i + 1 < p_count; i++) begin
			p_start[i] = p_start[i+1];
			p_size[i] = p_size[i+1];
			p_used[i] = p_used[i+1];
		end
		p_count--;
		p_start[p_count] = '0;
		p_size[p_count] = '0;
		p_used[p_count] = 1'b0;
	endfunction

	function automatic pfa_tb_pkg::alloc_rsp_t allocate(logic [19:0] want);
		pfa_tb_pkg::alloc_rsp_t r;
		int h;
		logic [19:0] pick;
		r = '0;
		h = p_count;
		pick = '0;
		if (want == 0) begin
			r.status = pfa_pkg::ST_ZERO;
			return r;
		end
		// scan for a hole by policy, earliest on ties
		for (int i = 0; i < p_count; i++) begin
			if (p_used[i] || p_size[i] < want) continue;
			if (policy == pfa_pkg::POL_FIRST) begin
				h = i;
				break;
			end
			if (h == p_count) begin
				h = i;
				pick = p_size[i];
			end else if (policy == pfa_pkg::POL_BEST ? p_size[i] < pick : p_size[i] > pick) begin
				h = i;
				pick = p_size[i];
			end
		end
		if (h >= p_count) begin
			r.status = pfa_pkg::ST_NOFIT;
			return r;
		end
		if (p_size[h] == want) begin
			p_used[h] = 1'b1;
			r.result_index = IDX_W'(h);
			return r;
		end
		if (p_count >= NPART) begin
			r.status = pfa_pkg::ST_FULL;
			return r;
		end
		// split: used part goes in front of the remainder
		for (int i = p_count; i > h; i--) begin
			p_start[i] = p_start[i-1];
			p_size[i] = p_size[i-1];
			p_used[i] = p_used[i-1];
		end
		p_count++;
		p_size[h] = want;
		p_used[h] = 1'b1;
		p_start[h+1] = p_start[h] + want;
		p_size[h+1] = p_size[h+1] - want;
		r.result_index = IDX_W'(h);
		return r;
	endfunction

	function automatic pfa_tb_pkg::alloc_rsp_t release_part(int idx);
		pfa_tb_pkg::alloc_rsp_t r;
		r = '0;
		if (idx == 0 || idx >= p_count || !p_used[idx]) begin
			r.status = pfa_pkg::ST_BADIDX;
			return r;
		end
		p_used[idx] = 1'b0;
		if (!p_used[idx-1]) begin
			p_size[idx-1] = p_size[idx-1] + p_size[idx];
			drop_entry(idx);
			idx--;
		end
		if (idx + 1 < p_count && !p_used[idx+1]) begin
			p_size[idx] = p_size[idx] + p_size[idx+1];
			drop_entry(idx + 1);
		end
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		pfa_tb_pkg::alloc_rsp_t got, want_rsp;
		if (!arst_n) begin
			policy = pfa_pkg::POL_FIRST;
			os_size = pfa_pkg::RESERVED_RST;
			free_size = pfa_pkg::POOL_RST;
			base_addr = '0;
			rebuild_table();
			expected_rsp.delete();
			errors = 0;
			pending = 0;
		end else begin
			// compare a response transfer against the oldest prediction
			if (rsp_valid && rsp_ready) begin
				got.status = rsp_status;
				got.result_index = rsp_index;
				if (expected_rsp.size() == 0) begin
					$display("%0t: unexpected response, expected none, actual %0d/%0d",
						$time, got.status, got.result_index);
					errors++;
				end else begin
					want_rsp = expected_rsp.pop_front();
					if (got.status !== want_rsp.status) begin
						$display("%0t: status expected %0d actual %0d",
							$time, want_rsp.status, got.status);
						errors++;
					end
					if (got.result_index !== want_rsp.result_index) begin
						$display("%0t: result_index expected %0d actual %0d",
							$time, want_rsp.result_index, got.result_index);
						errors++;
					end
				end
			end
			// predict a request transfer
			if (req_valid && req_ready) begin
				if (req_opcode == pfa_pkg::OP_ALLOC) expected_rsp.push_back(allocate(req_size));
				else expected_rsp.push_back(release_part(int'(req_index)));
			end
			// any register write rebuilds the table
			if (cfg_we) begin
				case (cfg_index)
					pfa_pkg::CFG_POLICY:   policy = cfg_data[1:0];
					pfa_pkg::CFG_RESERVED: os_size = cfg_data;
					pfa_pkg::CFG_POOL:     free_size = cfg_data;
					pfa_pkg::CFG_BASE:     base_addr = cfg_data;
					default:               ;
				endcase
				rebuild_table();
			end
			pending = expected_rsp.size();
		end
	end
endmodule
`default_nettype wire

// ===== dv/tb_partition_allocator_fit_top.sv =====
// Testbench top: clock, reset, register phases, request stimulus, response stalls and verdict.
`default_nettype none
module tb_partition_allocator_fit_top;
	timeunit 1ns;
	timeprecision 1ps;

	localparam longint CYCLE_LIMIT = 2000000;
	localparam int REQ_W     = pfa_pkg::REQ_W;
	localparam int IDX_W     = pfa_pkg::IDX_W;
	localparam int CFG_W     = pfa_pkg::CFG_W;
	localparam int CFG_IDX_W = pfa_pkg::CFG_IDX_W;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_W-1:0] cfg_data = '0;
	int errors, pending;
	longint cycles = 0;
	bit quiet = 1'b0;
	bit hold_off = 1'b0;

	pfa_req_if req ();
	pfa_rsp_if rsp ();

	partition_allocator_fit_top dut (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
		.cfg_data(cfg_data), .req(req.sink), .rsp(rsp.source)
	);

	pfa_checker chk (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
		.cfg_data(cfg_data), .req_valid(req.valid), .req_ready(req.ready),
		.req_opcode(req.opcode), .req_size(req.request_size),
		.req_index(req.part_index), .rsp_valid(rsp.valid), .rsp_ready(rsp.ready),
		.rsp_status(rsp.status), .rsp_index(rsp.result_index),
		.errors(errors), .pending(pending)
	);

	always #10 clk = ~clk;

	initial begin
		req.valid = 1'b0;
		req.opcode = pfa_pkg::OP_ALLOC;
		req.request_size = '0;
		req.part_index = '0;
		rsp.ready = 1'b0;
	end

	// cycle limit
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("partition_allocator_fit_top: mismatch");
			$finish;
		end
	end

	// response side: random stalls, none in quiet stretches, a full stall during a hold-off
	always @(posedge clk) begin
		if (arst_n)
			rsp.ready <= !hold_off && (quiet || $urandom_range(99) >= 11);
	end

	// valid stays high between back-to-back transfers; it drops only on idle cycles
	task automatic send(logic op, logic [REQ_W-1:0] sz, logic [IDX_W-1:0] ix);
		while (!quiet && $urandom_range(99) < 11) begin
			req.valid <= 1'b0;
			@(posedge clk);
		end
		req.valid <= 1'b1;
		req.opcode <= op;
		req.request_size <= sz;
		req.part_index <= ix;
		@(posedge clk);
		while (!req.ready) @(posedge clk);
	endtask

	task automatic wait_drained();
		req.valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
		wait_drained();
		repeat (140) @(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		repeat (3) @(posedge clk);
	endtask

	// mostly small sizes so splits and exact fits both happen
	function automatic logic [REQ_W-1:0] pick_size(logic [CFG_W-1:0] pool);
		int r;
		r = int'($urandom_range(99));
		if (r < 5) return '0;
		if (r < 8) return REQ_W'($urandom);
		if (r < 12) return pool;
		return REQ_W'($urandom_range(pool > 64 ? pool / 8 : 8, 1));
	endfunction

	task automatic random_phase(int n, logic [CFG_W-1:0] pool);
		logic [IDX_W-1:0] ix;
		for (int k = 0; k < n; k++) begin
			quiet = (k >= n / 3 && k < n / 2);
			if ($urandom_range(99) < 55) begin
				send(pfa_pkg::OP_ALLOC, pick_size(pool), IDX_W'($urandom));
			end else begin
				if ($urandom_range(99) < 15) ix = IDX_W'($urandom);
				else ix = IDX_W'($urandom_range(8, 1));
				send(pfa_pkg::OP_FREE, REQ_W'($urandom), ix);
			end
		end
		quiet = 1'b0;
	endtask

	initial begin
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		repeat (3) @(posedge clk);

		// directed: reset table, first fit
		send(pfa_pkg::OP_ALLOC, '0, '0);
		send(pfa_pkg::OP_ALLOC, 20'hFFFFF, '0);
		send(pfa_pkg::OP_FREE, '0, 6'd0);
		send(pfa_pkg::OP_FREE, '0, 6'd1);
		send(pfa_pkg::OP_FREE, '0, 6'd63);
		send(pfa_pkg::OP_ALLOC, 20'd100, 6'h3F);
		send(pfa_pkg::OP_ALLOC, 20'd50, '0);
		send(pfa_pkg::OP_ALLOC, 20'd100, '0);
		send(pfa_pkg::OP_FREE, '0, 6'd1);
		send(pfa_pkg::OP_FREE, '0, 6'd3);
		send(pfa_pkg::OP_FREE, '0, 6'd2);
		send(pfa_pkg::OP_ALLOC, 20'd600, '0);
		send(pfa_pkg::OP_FREE, '0, 6'd1);

		// fill table to full, then a split must fail
		write_reg(pfa_pkg::CFG_POOL, 20'd1000);
		for (int k = 0; k < 62; k++) send(pfa_pkg::OP_ALLOC, 20'd1, '0);
		send(pfa_pkg::OP_ALLOC, 20'd5, '0);
		send(pfa_pkg::OP_ALLOC, 20'd938, '0);
		send(pfa_pkg::OP_FREE, '0, 6'd63);

		// address wrap and zero pool
		write_reg(pfa_pkg::CFG_BASE, 20'hFFFF0);
		write_reg(pfa_pkg::CFG_RESERVED, 20'hFFFFF);
		send(pfa_pkg::OP_ALLOC, 20'd3, '0);
		write_reg(pfa_pkg::CFG_POOL, 20'd0);
		send(pfa_pkg::OP_ALLOC, 20'd1, '0);

		// long receiver hold-off while requests keep coming
		write_reg(pfa_pkg::CFG_POOL, 20'd600);
		fork
			begin
				hold_off = 1'b1;
				repeat (2000) @(posedge clk);
				hold_off = 1'b0;
			end
			random_phase(20, 20'd600);
		join

		// random phases across policies and sizes
		write_reg(pfa_pkg::CFG_POLICY, CFG_W'(pfa_pkg::POL_FIRST));
		write_reg(pfa_pkg::CFG_RESERVED, 20'd0);
		random_phase(150, 20'd600);
		write_reg(pfa_pkg::CFG_POLICY, CFG_W'(pfa_pkg::POL_BEST));
		write_reg(pfa_pkg::CFG_POOL, 20'hFFFFF);
		write_reg(pfa_pkg::CFG_RESERVED, 20'hFFFFF);
		random_phase(150, 20'hFFFFF);
		write_reg(pfa_pkg::CFG_POLICY, CFG_W'(pfa_pkg::POL_WORST));
		write_reg(pfa_pkg::CFG_BASE, 20'h12345);
		write_reg(pfa_pkg::CFG_POOL, 20'd300);
		random_phase(150, 20'd300);
		write_reg(pfa_pkg::CFG_POLICY, CFG_W'(pfa_pkg::POL_SPARE));
		write_reg(pfa_pkg::CFG_POOL, 20'd2000);
		random_phase(100, 20'd2000);

		wait_drained();
		repeat (200) @(posedge clk);
		if (errors == 0) $display("partition_allocator_fit_top: match");
		else $display("partition_allocator_fit_top: mismatch");
		$finish;
	end
endmodule
`default_nettype wire
